FILE: rtl/assert_macros.svh
// Assertion macros shared by the quantizer modules.
// No dependencies; included by files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: rtl/npq_pkg.sv
// Package for the pitch quantizer: widths, item types and the constant
// pitch, boundary and tie tables built at elaboration. No dependencies.
`timescale 1ns / 1ps

package npq_pkg;

   localparam int PITCH_COUNT       = 108;
   localparam int REFERENCE_INDEX   = 48;
   localparam int REFERENCE_HZ      = 440;
   localparam int STEPS_PER_OCTAVE  = 12;
   localparam int OCTAVE_OFFSET     = 11;
   localparam int BASE_SHIFT        = 24;
   localparam int HZ_FRAC_SHIFT     = 40;

   localparam int INDEX_WIDTH       = $clog2(PITCH_COUNT);
   localparam int SEARCH_LEVELS     = INDEX_WIDTH;
   localparam int TABLE_DEPTH       = 2 ** INDEX_WIDTH;

   localparam int FREQ_WIDTH        = 32;
   localparam int TOL_WIDTH         = 17;
   localparam int PITCH_INDEX_WIDTH = 7;
   localparam int FRAC_BITS         = 16;
   localparam int PRODUCT_WIDTH     = FREQ_WIDTH + TOL_WIDTH;

   localparam logic [TOL_WIDTH-1:0] TOLERANCE_RESET = 17'd66489;
   localparam logic [63:0]          ONE_Q62         = 64'h4000_0000_0000_0000;

   typedef logic [FREQ_WIDTH-1:0]      freq_type;
   typedef logic [INDEX_WIDTH-1:0]     index_type;
   typedef logic [TOL_WIDTH-1:0]       tol_type;
   typedef logic [PRODUCT_WIDTH-1:0]   product_type;
   typedef freq_type [TABLE_DEPTH-1:0] word_table_type;
   typedef logic [TABLE_DEPTH-1:0]     flag_table_type;

   typedef struct packed {
      logic      valid;
      freq_type  frequency;
      index_type index;
   } search_out_type;

   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[125:62];
   endfunction

   function automatic logic fits_twelfth(input logic [63:0] r);
      logic [63:0] acc;
      logic        ok;
      acc = r;
      ok  = 1'b1;
      for (int k = 1; k < STEPS_PER_OCTAVE; k++) begin
         acc = mul_q62(acc, r);
         if (acc > (ONE_Q62 << 1)) ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic logic [63:0] semitone_ratio();
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      lo = ONE_Q62;
      hi = ONE_Q62 + (ONE_Q62 >> 2);
      for (int n = 0; n < 64; n++) begin
         if (hi - lo > 64'd1) begin
            mid = lo + ((hi - lo) >> 1);
            if (fits_twelfth(mid)) lo = mid;
            else hi = mid;
         end
      end
      return lo;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] x_arg);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bit_v;
      x     = x_arg;
      res   = 64'd0;
      bit_v = 64'd1 << 62;
      for (int n = 0; n < 32; n++) begin
         if (x >= res + bit_v) begin
            x   = x - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   function automatic word_table_type build_pitch_table();
      word_table_type tbl;
      logic [63:0]    ratio [STEPS_PER_OCTAVE];
      logic [63:0]    step;
      logic [63:0]    v;
      int             m;
      int             oct;
      int             semi;
      int             shift;
      tbl      = '0;
      step     = semitone_ratio();
      ratio[0] = ONE_Q62;
      for (int i = 1; i < STEPS_PER_OCTAVE; i++) ratio[i] = mul_q62(ratio[i-1], step);
      for (int i = 0; i < PITCH_COUNT; i++) begin
         m     = i - REFERENCE_INDEX + OCTAVE_OFFSET * STEPS_PER_OCTAVE;
         oct   = m / STEPS_PER_OCTAVE - OCTAVE_OFFSET;
         semi  = m % STEPS_PER_OCTAVE;
         shift = BASE_SHIFT - oct;
         v     = mul_q62(64'(REFERENCE_HZ) << HZ_FRAC_SHIFT, ratio[semi]);
         v     = (v + (64'd1 << (shift - 1))) >> shift;
         tbl[i] = (v > 64'h0000_0000_FFFF_FFFF) ? '1 : v[FREQ_WIDTH-1:0];
      end
      return tbl;
   endfunction

   function automatic word_table_type build_boundary_table(input word_table_type pt);
      word_table_type tbl;
      logic [63:0]    r;
      tbl = '1;
      for (int i = 0; i + 1 < PITCH_COUNT; i++) begin
         r      = isqrt64(64'(pt[i]) * 64'(pt[i+1]));
         tbl[i] = r[FREQ_WIDTH-1:0];
      end
      return tbl;
   endfunction

   function automatic flag_table_type build_tie_table(input word_table_type pt,
                                                      input word_table_type bt);
      flag_table_type tbl;
      tbl = '0;
      for (int i = 0; i + 1 < PITCH_COUNT; i++) begin
         tbl[i] = ((64'(bt[i]) * 64'(bt[i])) == (64'(pt[i]) * 64'(pt[i+1])));
      end
      return tbl;
   endfunction

   localparam word_table_type PITCH_TABLE    = build_pitch_table();
   localparam word_table_type BOUNDARY_TABLE = build_boundary_table(PITCH_TABLE);
   localparam flag_table_type TIE_TABLE      = build_tie_table(PITCH_TABLE, BOUNDARY_TABLE);

endpackage

FILE: rtl/npq_search.sv
// Pipelined binary search of the frequency over the boundary table,
// one level per stage. Depends on npq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module npq_search (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  npq_pkg::freq_type       in_frequency,
   output npq_pkg::search_out_type result
);

   localparam int L = npq_pkg::SEARCH_LEVELS;

   logic                 valid_ff [L];
   npq_pkg::freq_type    freq_ff  [L];
   npq_pkg::index_type   index_ff [L];
   npq_pkg::index_type   index_in [L];

   genvar k;
   generate
      for (k = 0; k < L; k++) begin : g_level
         localparam int STEP = 2 ** (L - 1 - k);
         logic               prev_valid;
         npq_pkg::freq_type  prev_freq;
         npq_pkg::index_type prev_index;
         npq_pkg::index_type probe;

         if (k == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_freq  = in_frequency;
            assign prev_index = '0;
         end else begin : g_next
            assign prev_valid = valid_ff[k-1];
            assign prev_freq  = freq_ff[k-1];
            assign prev_index = index_ff[k-1];
         end

         assign probe = prev_index | npq_pkg::index_type'(STEP - 1);

         always_comb begin
            index_in[k] = prev_index;
            if (npq_pkg::BOUNDARY_TABLE[probe] < prev_freq) begin
               index_in[k] = prev_index | npq_pkg::index_type'(STEP);
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (advance) begin
               valid_ff[k] <= prev_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               freq_ff[k]  <= prev_freq;
               index_ff[k] <= index_in[k];
            end
         end
      end
   endgenerate

   assign result.valid     = valid_ff[L-1];
   assign result.frequency = freq_ff[L-1];
   assign result.index     = index_ff[L-1];

   `ASSERT_IMPLY(a_below_passed, clock, reset,
      valid_ff[L-1] && (index_ff[L-1] != '0),
      npq_pkg::BOUNDARY_TABLE[index_ff[L-1] - npq_pkg::index_type'(1)] < freq_ff[L-1])
   `ASSERT_IMPLY(a_above_not_passed, clock, reset,
      valid_ff[L-1] && (index_ff[L-1] < npq_pkg::index_type'(npq_pkg::PITCH_COUNT - 1)),
      npq_pkg::BOUNDARY_TABLE[index_ff[L-1]] >= freq_ff[L-1])

endmodule

FILE: rtl/npq_judge.sv
// Tie and zero check, pitch lookup, tolerance product and compare stages
// ending in the result register. Depends on npq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module npq_judge (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     advance,
   input  npq_pkg::search_out_type                  search_result,
   input  npq_pkg::tol_type                         tolerance,
   output logic                                     out_valid,
   output npq_pkg::freq_type                        out_pitch_frequency,
   output logic [npq_pkg::PITCH_INDEX_WIDTH-1:0]    out_pitch_index,
   output logic                                     out_found
);

   // lookup stage
   logic                a_valid_ff;
   logic                a_ok_ff;
   npq_pkg::freq_type   a_big_ff;
   npq_pkg::freq_type   a_small_ff;
   npq_pkg::freq_type   a_pitch_ff;
   npq_pkg::index_type  a_index_ff;
   npq_pkg::freq_type   pitch_in;
   logic                ok_in;
   logic                tie;

   // product stage
   logic                 b_valid_ff;
   logic                 b_ok_ff;
   npq_pkg::freq_type    b_big_ff;
   npq_pkg::product_type b_product_ff;
   npq_pkg::freq_type    b_pitch_ff;
   npq_pkg::index_type   b_index_ff;

   // result stage
   logic                                  out_valid_ff;
   logic                                  out_found_ff;
   npq_pkg::freq_type                     out_pitch_ff;
   logic [npq_pkg::PITCH_INDEX_WIDTH-1:0] out_index_ff;
   logic                                  found_in;
   npq_pkg::product_type                  scaled_big;

   assign pitch_in = npq_pkg::PITCH_TABLE[search_result.index];
   assign tie      = npq_pkg::TIE_TABLE[search_result.index] &&
                     (npq_pkg::BOUNDARY_TABLE[search_result.index] == search_result.frequency);
   assign ok_in    = !tie && (search_result.frequency != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= search_result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ok_ff    <= ok_in;
         a_pitch_ff <= pitch_in;
         a_index_ff <= search_result.index;
         if (search_result.frequency >= pitch_in) begin
            a_big_ff   <= search_result.frequency;
            a_small_ff <= pitch_in;
         end else begin
            a_big_ff   <= pitch_in;
            a_small_ff <= search_result.frequency;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_ok_ff      <= a_ok_ff;
         b_big_ff     <= a_big_ff;
         b_pitch_ff   <= a_pitch_ff;
         b_index_ff   <= a_index_ff;
         b_product_ff <= npq_pkg::PRODUCT_WIDTH'(a_small_ff) *
                         npq_pkg::PRODUCT_WIDTH'(tolerance);
      end
   end

   assign scaled_big = npq_pkg::PRODUCT_WIDTH'({b_big_ff, npq_pkg::FRAC_BITS'(0)});
   assign found_in   = b_ok_ff && (scaled_big <= b_product_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_found_ff <= found_in;
         out_pitch_ff <= found_in ? b_pitch_ff : '0;
         out_index_ff <= found_in ? npq_pkg::PITCH_INDEX_WIDTH'(b_index_ff) : '0;
      end
   end

   assign out_valid           = out_valid_ff;
   assign out_found           = out_found_ff;
   assign out_pitch_frequency = out_pitch_ff;
   assign out_pitch_index     = out_index_ff;

   `ASSERT_IMPLY(a_found_pitch_matches, clock, reset,
      out_valid_ff && out_found_ff,
      out_pitch_ff == npq_pkg::PITCH_TABLE[out_index_ff[npq_pkg::INDEX_WIDTH-1:0]])
   `ASSERT_IMPLY(a_found_index_in_range, clock, reset,
      out_valid_ff && out_found_ff,
      out_index_ff < npq_pkg::PITCH_INDEX_WIDTH'(npq_pkg::PITCH_COUNT))
   `ASSERT_IMPLY(a_miss_is_zero, clock, reset,
      out_valid_ff && !out_found_ff,
      (out_pitch_ff == '0) && (out_index_ff == '0))

endmodule

FILE: rtl/nearest_pitch_quantizer.sv
// Top level of the nearest pitch quantizer: handshake, tolerance register,
// search and judge pipelines. Depends on npq_pkg, npq_search, npq_judge.
//
//   channel  direction  handshake        payload
//   req      in         valid / ready    frequency (Q16.16 Hz)
//   rsp      out        valid / ready    pitch_frequency, pitch_index, found
//   csr      in         write enable     tolerance_ratio (Q1.16)
//
// One item per cycle while the result is not stalled; one stage per level
// of the boundary table search, then lookup, product and result stages.
// All stages advance together; a stalled result holds the pipeline and
// nothing is lost or repeated. Reset clears the valid bits and loads the
// default tolerance; the tables are constants.
`timescale 1ns / 1ps

module nearest_pitch_quantizer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [npq_pkg::FREQ_WIDTH-1:0]        req_frequency,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [npq_pkg::FREQ_WIDTH-1:0]        rsp_pitch_frequency,
   output logic [npq_pkg::PITCH_INDEX_WIDTH-1:0] rsp_pitch_index,
   output logic                                  rsp_found,
   input  logic                                  csr_write_enable,
   input  logic [npq_pkg::TOL_WIDTH-1:0]         csr_write_data
);

   npq_pkg::tol_type        tolerance_ff;
   npq_pkg::search_out_type search_result;
   logic                    advance;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= npq_pkg::TOLERANCE_RESET;
      end else if (csr_write_enable) begin
         tolerance_ff <= csr_write_data;
      end
   end

   npq_search u_search (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req_valid),
      .in_frequency (req_frequency),
      .result       (search_result)
   );

   npq_judge u_judge (
      .clock               (clock),
      .reset               (reset),
      .advance             (advance),
      .search_result       (search_result),
      .tolerance           (tolerance_ff),
      .out_valid           (rsp_valid),
      .out_pitch_frequency (rsp_pitch_frequency),
      .out_pitch_index     (rsp_pitch_index),
      .out_found           (rsp_found)
   );

endmodule

FILE: tb/tb_nearest_pitch_quantizer.sv
// Testbench for nearest_pitch_quantizer: random and directed frequencies against a
// scoreboard that rebuilds the equal-tempered pitch and boundary tables itself.
// Depends on npq_pkg and the nearest_pitch_quantizer RTL.
`timescale 1ns / 1ps

module tb_nearest_pitch_quantizer;

   localparam int          PITCHES     = npq_pkg::PITCH_COUNT;
   localparam int          SEMITONES   = 12;
   localparam int          OCTAVE_BIAS = 11;
   localparam logic [63:0] UNITY_Q62   = 64'h4000_0000_0000_0000;
   localparam int          DRAIN_CYCLES = 14;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          PHASE_ITEMS  = 87;

   typedef logic [npq_pkg::FREQ_WIDTH-1:0]        freq_t;
   typedef logic [npq_pkg::TOL_WIDTH-1:0]         tol_t;
   typedef logic [npq_pkg::PITCH_INDEX_WIDTH-1:0] pitch_index_t;

   typedef struct packed {
      freq_t        pitch_frequency;
      pitch_index_t pitch_index;
      logic         found;
   } pitch_result_t;

   function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] wide;
      wide = 128'(a) * 128'(b);
      return 64'(wide >> 62);
   endfunction

   function automatic logic twelfth_within_octave(input logic [63:0] r);
      logic [63:0] acc;
      acc = r;
      for (int k = 1; k < SEMITONES; k++) begin
         acc = q62_mul(acc, r);
         if (acc > (UNITY_Q62 << 1)) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [31:0] root_floor(input logic [63:0] x);
      logic [63:0] trial;
      logic [31:0] res;
      res = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = 64'(res | (32'd1 << b));
         if (trial * trial <= x) res = trial[31:0];
      end
      return res;
   endfunction

   class pitch_scoreboard;
      freq_t         pitch_hz [PITCHES];
      freq_t         boundary_hz [PITCHES-1];
      tol_t          tolerance;
      pitch_result_t expected_q [$];
      int            mismatches;

      function new();
         logic [63:0] lo;
         logic [63:0] hi;
         logic [63:0] mid;
         logic [63:0] v;
         logic [63:0] ratios [SEMITONES];
         int          m;
         int          oct;
         int          shift;
         lo = UNITY_Q62;
         hi = UNITY_Q62 + (UNITY_Q62 >> 2);
         while (hi - lo > 64'd1) begin
            mid = lo + ((hi - lo) >> 1);
            if (twelfth_within_octave(mid)) lo = mid;
            else hi = mid;
         end
         ratios[0] = UNITY_Q62;
         for (int i = 1; i < SEMITONES; i++) ratios[i] = q62_mul(ratios[i-1], lo);
         for (int i = 0; i < PITCHES; i++) begin
            m     = i - npq_pkg::REFERENCE_INDEX + OCTAVE_BIAS * SEMITONES;
            oct   = m / SEMITONES - OCTAVE_BIAS;
            shift = 24 - oct;
            v     = q62_mul(64'(npq_pkg::REFERENCE_HZ) << 40, ratios[m % SEMITONES]);
            v     = (v + (64'd1 << (shift - 1))) >> shift;
            pitch_hz[i] = (v > 64'h0000_0000_FFFF_FFFF) ? '1 : v[31:0];
         end
         for (int i = 0; i + 1 < PITCHES; i++)
            boundary_hz[i] = root_floor(64'(pitch_hz[i]) * 64'(pitch_hz[i+1]));
         tolerance  = npq_pkg::TOLERANCE_RESET;
         mismatches = 0;
      endfunction

      function logic is_tie(input int j);
         return 64'(boundary_hz[j]) * 64'(boundary_hz[j]) ==
                64'(pitch_hz[j]) * 64'(pitch_hz[j+1]);
      endfunction

      function pitch_result_t quantize(input freq_t freq);
         logic [63:0]   f;
         logic [63:0]   p;
         int            idx;
         logic          tie;
         logic          hit;
         pitch_result_t r;
         f   = 64'(freq);
         idx = 0;
         tie = 1'b0;
         for (int j = 0; j + 1 < PITCHES; j++) begin
            if (f > 64'(boundary_hz[j])) idx++;
            else if (f == 64'(boundary_hz[j]) && is_tie(j)) tie = 1'b1;
         end
         p   = 64'(pitch_hz[idx]);
         hit = 1'b0;
         if (f != 0 && !tie) begin
            if (f >= p) hit = (f << 16) <= p * 64'(tolerance);
            else hit = (p << 16) <= f * 64'(tolerance);
         end
         r.pitch_frequency = hit ? p[31:0] : '0;
         r.pitch_index     = hit ? pitch_index_t'(idx) : '0;
         r.found           = hit;
         return r;
      endfunction

      function void note_frequency(input freq_t freq);
         expected_q.push_back(quantize(freq));
      endfunction

      function void check_result(input freq_t pf, input pitch_index_t pi, input logic fnd);
         pitch_result_t want;
         if (expected_q.size() == 0) begin
            $error("unexpected result: pitch_frequency %0d pitch_index %0d found %0d",
                   pf, pi, fnd);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         if (pf !== want.pitch_frequency) begin
            $error("pitch_frequency: expected %0d, actual %0d", want.pitch_frequency, pf);
            mismatches++;
         end
         if (pi !== want.pitch_index) begin
            $error("pitch_index: expected %0d, actual %0d", want.pitch_index, pi);
            mismatches++;
         end
         if (fnd !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, fnd);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic         clock;
   logic         reset            = 1'b1;
   logic         req_valid        = 1'b0;
   logic         req_ready;
   freq_t        req_frequency    = '0;
   logic         rsp_valid;
   logic         rsp_ready        = 1'b0;
   freq_t        rsp_pitch_frequency;
   pitch_index_t rsp_pitch_index;
   logic         rsp_found;
   logic         csr_write_enable = 1'b0;
   tol_t         csr_write_data   = '0;

   pitch_scoreboard board;
   logic            no_idle = 1'b0;
   int              cycles  = 0;

   nearest_pitch_quantizer i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_frequency       (req_frequency),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pitch_frequency (rsp_pitch_frequency),
      .rsp_pitch_index     (rsp_pitch_index),
      .rsp_found           (rsp_found),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(99) >= 23);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_pitch_frequency, rsp_pitch_index, rsp_found);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_frequency(input freq_t freq);
      while (!no_idle && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_frequency <= freq;
      do @(posedge clock); while (!req_ready);
      board.note_frequency(freq);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_tolerance(input tol_t value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.tolerance = value;
   endtask

   function automatic freq_t random_frequency();
      logic [63:0] p;
      logic [63:0] edge_hz;
      int          k;
      p = 64'(board.pitch_hz[$urandom_range(PITCHES-1)]);
      k = $urandom_range(99);
      if (k < 20) return $urandom;
      if (k < 50) return freq_t'(p - (p >> 5) + $urandom_range(32'(p >> 4)));
      if (k < 75) begin
         if ($urandom_range(1)) edge_hz = (p * 64'(board.tolerance)) >> 16;
         else if (board.tolerance == 0) edge_hz = p;
         else edge_hz = ((p << 16) + 64'(board.tolerance) - 1) / 64'(board.tolerance);
         return freq_t'(edge_hz + 64'($urandom_range(2)) - 64'd1);
      end
      if (k < 90)
         return board.boundary_hz[$urandom_range(PITCHES-2)] + $urandom_range(2) - 1;
      if (k < 95) return $urandom_range(board.pitch_hz[0]);
      return $urandom | 32'h8000_0000;
   endfunction

   initial begin
      freq_t       directed [$];
      tol_t        settings [7];
      logic [63:0] ref_p;
      int          tie_at;

      board = new();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      tie_at = 60;
      for (int j = 0; j + 1 < PITCHES; j++)
         if (board.is_tie(j)) tie_at = j;

      ref_p = 64'(board.pitch_hz[npq_pkg::REFERENCE_INDEX]);
      directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000,
                   board.pitch_hz[0], board.pitch_hz[0] - 1, board.pitch_hz[0] >> 1,
                   board.pitch_hz[PITCHES-1], board.pitch_hz[PITCHES-1] + 1,
                   board.pitch_hz[npq_pkg::REFERENCE_INDEX],
                   board.boundary_hz[0], board.boundary_hz[0] + 1,
                   board.boundary_hz[47], board.boundary_hz[47] + 1,
                   board.boundary_hz[PITCHES-2], board.boundary_hz[PITCHES-2] + 1,
                   board.boundary_hz[tie_at], board.boundary_hz[tie_at] + 1};
      directed.push_back(freq_t'((ref_p * 64'(board.tolerance)) >> 16));
      directed.push_back(freq_t'(((ref_p * 64'(board.tolerance)) >> 16) + 1));
      directed.push_back(freq_t'(((ref_p << 16) + 64'(board.tolerance) - 1) /
                                 64'(board.tolerance)));
      directed.push_back(freq_t'((((ref_p << 16) + 64'(board.tolerance) - 1) /
                                  64'(board.tolerance)) - 1));

      foreach (directed[i]) send_frequency(directed[i]);
      repeat (PHASE_ITEMS) send_frequency(random_frequency());

      settings = '{17'd65536, 17'd92682, 17'd131071, 17'd0, 17'd65535,
                   tol_t'($urandom_range(92682, 65536)), tol_t'($urandom)};
      for (int ph = 0; ph < 7; ph++) begin
         drain_pipeline();
         write_tolerance(settings[ph]);
         no_idle = (ph == 2);
         repeat (PHASE_ITEMS) send_frequency(random_frequency());
      end

      no_idle = 1'b0;
      drain_pipeline();
      if (board.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
